FILE: hdl/tle_pkg.sv
// Shared types, constants and the erase sequence for the terminal line editor.
`default_nettype none
package tle_pkg;

  // Capacity ceiling of the line buffer, in bytes
  localparam int LINE_MAX = 256;
  localparam int CAP_MAX  = (LINE_MAX < 256) ? LINE_MAX : 256;
  localparam int CAP_MIN  = 2;

  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_DEL = 8'd127;
  localparam logic [7:0] BYTE_NUL = 8'd0;

  // One result beat, without the always-set echo flag
  typedef struct packed {
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;
  } tle_beat_t;

  // Decoder verdict for one received byte
  typedef struct packed {
    logic      emit;     // byte causes at least one beat
    logic      erase;    // beat opens the eight-beat erase sequence
    logic [7:0] pos_nxt;
    tle_beat_t beat;
  } tle_dec_t;

  // ESC [ 1 D ESC [ 1 P
  function automatic logic [7:0] erase_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0, 3'd4: b = BYTE_ESC;
      3'd1, 3'd5: b = 8'h5B;
      3'd2, 3'd6: b = 8'h31;
      3'd3:       b = 8'h44;
      default:    b = 8'h50;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tle_decode.sv
// Byte classifier: works out the first result beat and the next write position.
`default_nettype none
module tle_decode (
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       wr_pos,
  input  wire logic [8:0]       buffer_size,
  output tle_pkg::tle_dec_t     dec
);
  import tle_pkg::*;

  logic [8:0] cap;
  logic [7:0] limit;
  logic [7:0] end_pos;

  always_comb begin
    cap = buffer_size;
    if (cap > 9'(CAP_MAX)) cap = 9'(CAP_MAX);
    if (cap < 9'(CAP_MIN)) cap = 9'(CAP_MIN);
    limit   = 8'(cap - 9'd1);
    end_pos = (wr_pos > limit) ? limit : wr_pos;

    dec       = '0;
    dec.pos_nxt = wr_pos;

    if (rx_byte == BYTE_CR || rx_byte == BYTE_LF) begin
      dec.emit             = 1'b1;
      dec.pos_nxt          = '0;
      dec.beat.echo_byte   = BYTE_LF;
      dec.beat.store_valid = 1'b1;
      dec.beat.store_index = end_pos;
      dec.beat.store_byte  = BYTE_NUL;
      dec.beat.line_done   = 1'b1;
      dec.beat.line_length = end_pos;
      dec.beat.last        = 1'b1;
    end else if (wr_pos >= limit || rx_byte == BYTE_TAB) begin
      // full buffer or tab: dropped
    end else if (rx_byte == BYTE_DEL) begin
      if (wr_pos != '0) begin
        dec.emit           = 1'b1;
        dec.erase          = 1'b1;
        dec.pos_nxt        = wr_pos - 8'd1;
        dec.beat.echo_byte = erase_byte(3'd0);
      end
    end else begin
      dec.emit             = 1'b1;
      dec.pos_nxt          = wr_pos + 8'd1;
      dec.beat.echo_byte   = rx_byte;
      dec.beat.store_valid = 1'b1;
      dec.beat.store_index = wr_pos;
      dec.beat.store_byte  = rx_byte;
      dec.beat.last        = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tle_out.sv
// Result register with the erase-sequence counter.
`default_nettype none
module tle_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire tle_pkg::tle_beat_t load_beat,
  output logic                   load_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tle_pkg::tle_beat_t     out_beat
);
  import tle_pkg::*;

  logic       valid_r, valid_nxt;
  tle_beat_t  beat_r, beat_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       fire;

  assign fire    = valid_r && out_ready;
  // free once empty or once the final beat of the current byte leaves
  assign load_ok = !valid_r || (fire && beat_r.last);

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    cnt_nxt   = cnt_r;
    if (load && load_ok) begin
      valid_nxt = 1'b1;
      beat_nxt  = load_beat;
      cnt_nxt   = '0;
    end else if (fire && !beat_r.last) begin
      cnt_nxt            = cnt_r + 3'd1;
      beat_nxt.echo_byte = erase_byte(cnt_nxt);
      beat_nxt.last      = (cnt_nxt == '1);
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule
`default_nettype wire

FILE: hdl/terminal_line_editor.sv
// Top level of the terminal line editor: input register, position and capacity state.
//
// Usage:
//   in_*  : one received terminal byte per beat (in_tdata[7:0]).
//   out_* : result beats for the terminal echo and the line buffer writes.
//           out_tlast marks the final beat caused by one received byte.
//   cfg_* : cfg_we writes the 9-bit buffer_size (capacity incl. terminator).
// Path: an accepted byte passes the input register and then the result
//   register before its first result beat shows.
// Throughput: one byte per cycle for printable bytes, CR/LF and dropped
//   bytes while out_tready stays high; DEL holds the result register for
//   its eight erase beats, paced by the single result register and its
//   sequence counter, so no new byte loads until the last of them leaves.
// Reset (rst_n low, synchronous): write position 0, buffer_size 256,
//   both registers emptied.
// Stall: while out_tready is low the result beat holds; the input register
//   still takes one more byte and then in_tready drops until the result
//   register frees up.
`default_nettype none
module terminal_line_editor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] echo_byte, [15:8] store_index,
                                       // [23:16] store_byte, [31:24] line_length
  output logic [2:0]       out_tuser,  // [0] echo_valid, [1] store_valid, [2] line_done
  output logic             out_tlast,  // last beat for this received byte
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata   // buffer_size
);
  import tle_pkg::*;

  localparam logic [8:0] BUF_SIZE_RST = 9'd256;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic [7:0] wr_pos_r, wr_pos_nxt;
  logic [8:0] buf_size_r;

  tle_dec_t   dec;
  tle_beat_t  beat;
  logic       load_ok;
  logic       consume;
  logic       in_fire;

  tle_decode u_decode (
    .rx_byte     (s1_byte_r),
    .wr_pos      (wr_pos_r),
    .buffer_size (buf_size_r),
    .dec         (dec)
  );

  // a byte with no result leaves the input register at once
  assign consume   = s1_valid_r && (!dec.emit || load_ok);
  assign in_tready = !s1_valid_r || consume;
  assign in_fire   = in_tvalid && in_tready;

  tle_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid_r && dec.emit),
    .load_beat (dec.beat),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_beat  (beat)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (consume) s1_valid_nxt = 1'b0;
    wr_pos_nxt = consume ? dec.pos_nxt : wr_pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_pos_r   <= '0;
      buf_size_r <= BUF_SIZE_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      wr_pos_r   <= wr_pos_nxt;
      if (cfg_we) buf_size_r <= cfg_wdata;
    end
    if (in_fire) s1_byte_r <= in_tdata;
  end

  assign out_tdata = {beat.line_length, beat.store_byte, beat.store_index, beat.echo_byte};
  assign out_tuser = {beat.line_done, beat.store_valid, 1'b1};
  assign out_tlast = beat.last;

endmodule
`default_nettype wire
